@@ src/tmvd_pkg.sv @@
`timescale 1ns / 1ps
package tmvd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int STOP_W    = 12;
  localparam int MAG_W     = 24;
  localparam int ERR_W     = 50;
  localparam int OUT_W     = 16;
  localparam int X_W       = 18;
  localparam int RECIP_SH  = 19;
  localparam logic [X_W-1:0]   RECIP3    = X_W'(174763);
  localparam logic [ERR_W-1:0] START_ERR = ERR_W'(64'd1638400000000);

  typedef enum logic [2:0] {
    REG_PERM_COUNT = 3'd0,
    REG_MAT1_LOW   = 3'd1,
    REG_MAT2_LOW   = 3'd2,
    REG_MAT3_LOW   = 3'd3,
    REG_MAT1_HIGH  = 3'd4,
    REG_MAT2_HIGH  = 3'd5,
    REG_MAT3_HIGH  = 3'd6,
    REG_STOP_STEP  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]                 perm_count;
    logic signed [SAMPLE_W-1:0] dl1;
    logic signed [SAMPLE_W-1:0] dl2;
    logic signed [SAMPLE_W-1:0] dl3;
    logic signed [SAMPLE_W-1:0] dh1;
    logic signed [SAMPLE_W-1:0] dh2;
    logic signed [SAMPLE_W-1:0] dh3;
    logic [STOP_W-1:0]          stop_step;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sl;
    logic signed [SAMPLE_W-1:0] sh;
    logic                       last;
  } vox_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] cnt;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ev_stat_t;

endpackage

@@ src/tmvd_front.sv @@
`timescale 1ns / 1ps
module tmvd_front (
  input  tmvd_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_sample_low,
  input  logic signed [15:0]               in_sample_high,
  input  logic                             in_last_voxel,
  input  tmvd_pkg::q_stat_t                q_stat,
  output logic                             push,
  output tmvd_pkg::vox_t                   push_data
);
  import tmvd_pkg::*;

  logic signed [SAMPLE_W-1:0] mn_l, mx_l, mn_h, mx_h;

  // span of the three densities per image
  always_comb begin
    mn_l = cfg.dl1;
    mx_l = cfg.dl1;
    if (cfg.dl2 < mn_l) mn_l = cfg.dl2;
    if (cfg.dl3 < mn_l) mn_l = cfg.dl3;
    if (cfg.dl2 > mx_l) mx_l = cfg.dl2;
    if (cfg.dl3 > mx_l) mx_l = cfg.dl3;
    mn_h = cfg.dh1;
    mx_h = cfg.dh1;
    if (cfg.dh2 < mn_h) mn_h = cfg.dh2;
    if (cfg.dh3 < mn_h) mn_h = cfg.dh3;
    if (cfg.dh2 > mx_h) mx_h = cfg.dh2;
    if (cfg.dh3 > mx_h) mx_h = cfg.dh3;
  end

  always_comb begin
    push_data.last = in_last_voxel;
    if (in_sample_low < mn_l)      push_data.sl = mn_l;
    else if (in_sample_low > mx_l) push_data.sl = mx_l;
    else                           push_data.sl = in_sample_low;
    if (in_sample_high < mn_h)      push_data.sh = mn_h;
    else if (in_sample_high > mx_h) push_data.sh = mx_h;
    else                            push_data.sh = in_sample_high;
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule

@@ src/tmvd_fifo.sv @@
`timescale 1ns / 1ps
module tmvd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tmvd_pkg::vox_t    push_data,
  input  logic              pop,
  output tmvd_pkg::vox_t    pop_data,
  output tmvd_pkg::q_stat_t q_stat
);
  import tmvd_pkg::*;

  vox_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.cnt   = cnt_r;

endmodule

@@ src/tmvd_eval.sv @@
`timescale 1ns / 1ps
module tmvd_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [FRAC_BITS:0]       ab,
  input  logic [FRAC_BITS:0]       ratio,
  input  logic signed [16:0]       dd12_l,
  input  logic signed [16:0]       dd23_l,
  input  logic signed [16:0]       off_l,
  input  logic signed [16:0]       dd12_h,
  input  logic signed [16:0]       dd23_h,
  input  logic signed [16:0]       off_h,
  output tmvd_pkg::ev_stat_t       stat,
  output logic [tmvd_pkg::ERR_W-1:0] err,
  output logic [FRAC_BITS:0]       a
);
  import tmvd_pkg::*;

  localparam int FW  = FRAC_BITS + 1;
  localparam int OPW = (FRAC_BITS + 2 > MAG_W + 1) ? FRAC_BITS + 2 : MAG_W + 1;
  localparam int PW  = 2 * OPW;
  localparam int DW  = FRAC_BITS + 21;
  localparam int SH  = FRAC_BITS - 8;

  logic [2:0]              s_r;
  logic                    busy_r, done_r;
  logic signed [OPW-1:0]   op_a, op_b;
  logic signed [PW-1:0]    prod, p_r;
  logic [FW-1:0]           a_r;
  logic signed [DW-1:0]    acc_l_r, acc_h_r, p_d, off_l_s, off_h_s, sum_l, sum_h;
  logic signed [DW-1:0]    abs_l, abs_h;
  logic [MAG_W-1:0]        mag_l_r, mag_h_r;
  logic [ERR_W-1:0]        err_r, sq;

  // one shared multiplier, one product a cycle
  always_comb begin
    case (s_r)
      3'd0: begin
        op_a = $signed({{(OPW-FW){1'b0}}, ab});
        op_b = $signed({{(OPW-FW){1'b0}}, ratio});
      end
      3'd1: begin
        op_a = $signed({{(OPW-FW){1'b0}}, ab});
        op_b = $signed({{(OPW-17){dd23_l[16]}}, dd23_l});
      end
      3'd2: begin
        op_a = $signed({{(OPW-FW){1'b0}}, ab});
        op_b = $signed({{(OPW-17){dd23_h[16]}}, dd23_h});
      end
      3'd3: begin
        op_a = $signed({{(OPW-FW){1'b0}}, a_r});
        op_b = $signed({{(OPW-17){dd12_l[16]}}, dd12_l});
      end
      3'd4: begin
        op_a = $signed({{(OPW-FW){1'b0}}, a_r});
        op_b = $signed({{(OPW-17){dd12_h[16]}}, dd12_h});
      end
      3'd5: begin
        op_a = $signed({{(OPW-MAG_W){1'b0}}, mag_l_r});
        op_b = $signed({{(OPW-MAG_W){1'b0}}, mag_l_r});
      end
      3'd6: begin
        op_a = $signed({{(OPW-MAG_W){1'b0}}, mag_h_r});
        op_b = $signed({{(OPW-MAG_W){1'b0}}, mag_h_r});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod    = op_a * op_b;
  assign p_d     = p_r[DW-1:0];
  assign off_l_s = $signed({{(DW-17-FRAC_BITS){off_l[16]}}, off_l, {FRAC_BITS{1'b0}}});
  assign off_h_s = $signed({{(DW-17-FRAC_BITS){off_h[16]}}, off_h, {FRAC_BITS{1'b0}}});
  assign sum_l   = acc_l_r + p_d;
  assign sum_h   = acc_h_r + p_d;
  assign abs_l   = sum_l[DW-1] ? -sum_l : sum_l;
  assign abs_h   = sum_h[DW-1] ? -sum_h : sum_h;
  assign sq      = {{(ERR_W-2*MAG_W){1'b0}}, p_r[2*MAG_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r    <= 3'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (s_r == 3'd7);
      if (start) begin
        busy_r <= 1'b1;
        s_r    <= 3'd0;
      end else if (busy_r) begin
        s_r <= s_r + 3'd1;
        if (s_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod;
    if (busy_r) begin
      case (s_r)
        3'd1: a_r     <= p_r[FRAC_BITS +: FW];
        3'd2: acc_l_r <= off_l_s + p_d;
        3'd3: acc_h_r <= off_h_s + p_d;
        3'd4: mag_l_r <= abs_l[SH +: MAG_W];
        3'd5: mag_h_r <= abs_h[SH +: MAG_W];
        3'd6: err_r   <= sq;
        3'd7: err_r   <= err_r + sq;
        default: ;
      endcase
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign err       = err_r;
  assign a         = a_r;

endmodule

@@ src/tmvd_back.sv @@
`timescale 1ns / 1ps
module tmvd_back #(
  parameter int FRAC_BITS = 16,
  parameter int OUT_MAX   = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tmvd_pkg::cfg_t    cfg,
  input  tmvd_pkg::q_stat_t q_stat,
  input  tmvd_pkg::vox_t    q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_fraction_one,
  output logic [15:0]       out_fraction_two,
  output logic [15:0]       out_fraction_three,
  output logic              out_last_out
);
  import tmvd_pkg::*;

  localparam int FW  = FRAC_BITS + 1;
  localparam int TW  = FRAC_BITS + 2;
  localparam int CW  = FW + 16;
  localparam int ONE = 1 << FRAC_BITS;
  localparam logic [FW-1:0] ONE_Q = FW'(ONE);
  localparam logic signed [FW+1:0] ONE_S = (FW+2)'(ONE);
  localparam logic [FW-1:0] STEP0 = FW'((ONE + 10) / 20);
  localparam logic [FW-1:0] GRID [11] = '{
    FW'((0 * ONE + 5) / 10), FW'((1 * ONE + 5) / 10), FW'((2 * ONE + 5) / 10),
    FW'((3 * ONE + 5) / 10), FW'((4 * ONE + 5) / 10), FW'((5 * ONE + 5) / 10),
    FW'((6 * ONE + 5) / 10), FW'((7 * ONE + 5) / 10), FW'((8 * ONE + 5) / 10),
    FW'((9 * ONE + 5) / 10), FW'((10 * ONE + 5) / 10)
  };
  localparam logic [OUT_W-1:0] OMAX = OUT_W'(OUT_MAX);
  localparam logic [3:0] GRID_LAST = 4'd10;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PERM  = 9'b000000010,
    S_GRID  = 9'b000000100,
    S_SCHK  = 9'b000001000,
    S_SRCH  = 9'b000010000,
    S_FINAL = 9'b000100000,
    S_OMUL  = 9'b001000000,
    S_ODIV  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    DIR_AB_UP    = 2'd0,
    DIR_RATIO_UP = 2'd1,
    DIR_AB_DN    = 2'd2,
    DIR_RATIO_DN = 2'd3
  } dir_t;

  state_t               state_r;
  logic signed [15:0]   sl_r, sh_r;
  logic                 last_r;
  logic [1:0]           perm_r, fidx_r;
  logic [TW-1:0]        tot_r [3];
  logic [3:0]           ka_r, kr_r;
  dir_t                 j_r;
  logic [FW-1:0]        best_ab_r, best_rt_r, min_ab_r, low_rt_r, step_r;
  logic [FW-1:0]        pt_ab_r, pt_ratio_r;
  logic [ERR_W-1:0]     best_err_r, cur_err_r, min_err_r;
  logic signed [16:0]   dd12_l_r, dd23_l_r, off_l_r, dd12_h_r, dd23_h_r, off_h_r;
  logic                 ev_start_r, ev_start_nxt;
  logic [TW+OUT_W-1:0]  prod_r;
  logic [OUT_W-1:0]     q_r [3];
  logic                 out_valid_r, last_out_r;
  logic [OUT_W-1:0]     f1_r, f2_r, f3_r;

  ev_stat_t             ev_stat;
  logic [ERR_W-1:0]     ev_err;
  logic [FW-1:0]        ev_a;

  logic [1:0]           count_eff;
  logic [STOP_W-1:0]    stop_eff;
  logic                 search_go;
  logic signed [15:0]   da_l, db_l, dc_l, da_h, db_h, dc_h;
  logic                 first_c;
  logic [ERR_W-1:0]     min_e;
  logic [FW-1:0]        min_ab_v, low_rt_v, fa, fb, fc;
  logic [X_W-1:0]       x;
  logic [2*X_W-1:0]     x3;
  logic [OUT_W-1:0]     qv;
  dir_t                 j_next;

  function automatic logic [FW-1:0] clamp_q(input logic signed [FW+1:0] v);
    if (v < 0) return '0;
    else if (v > ONE_S) return ONE_Q;
    else return v[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] cand_ab(input dir_t j, input logic [FW-1:0] ab,
                                            input logic [FW-1:0] st);
    logic signed [FW+1:0] v;
    v = $signed({2'b00, ab});
    if (j == DIR_AB_UP)      v = v + $signed({2'b00, st});
    else if (j == DIR_AB_DN) v = v - $signed({2'b00, st});
    return clamp_q(v);
  endfunction

  function automatic logic [FW-1:0] cand_ratio(input dir_t j, input logic [FW-1:0] r,
                                               input logic [FW-1:0] st);
    logic signed [FW+1:0] v;
    v = $signed({2'b00, r});
    if (j == DIR_RATIO_UP)      v = v + $signed({2'b00, st});
    else if (j == DIR_RATIO_DN) v = v - $signed({2'b00, st});
    return clamp_q(v);
  endfunction

  tmvd_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ev_start_r),
    .ab     (pt_ab_r),
    .ratio  (pt_ratio_r),
    .dd12_l (dd12_l_r),
    .dd23_l (dd23_l_r),
    .off_l  (off_l_r),
    .dd12_h (dd12_h_r),
    .dd23_h (dd23_h_r),
    .off_h  (off_h_r),
    .stat   (ev_stat),
    .err    (ev_err),
    .a      (ev_a)
  );

  assign count_eff = (cfg.perm_count == 2'd0) ? 2'd1 : cfg.perm_count;
  assign stop_eff  = (cfg.stop_step == '0) ? STOP_W'(1) : cfg.stop_step;
  assign search_go = {step_r, 16'b0} >=
                     {{(CW-STOP_W-FRAC_BITS){1'b0}}, stop_eff, {FRAC_BITS{1'b0}}};
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;

  // role densities for the current material ordering
  always_comb begin
    case (perm_r)
      2'd0: begin
        da_l = cfg.dl1; db_l = cfg.dl2; dc_l = cfg.dl3;
        da_h = cfg.dh1; db_h = cfg.dh2; dc_h = cfg.dh3;
      end
      2'd1: begin
        da_l = cfg.dl3; db_l = cfg.dl1; dc_l = cfg.dl2;
        da_h = cfg.dh3; db_h = cfg.dh1; dc_h = cfg.dh2;
      end
      default: begin
        da_l = cfg.dl2; db_l = cfg.dl3; dc_l = cfg.dl1;
        da_h = cfg.dh2; db_h = cfg.dh3; dc_h = cfg.dh1;
      end
    endcase
  end

  // start pulse for the point evaluator
  always_comb begin
    unique case (state_r)
      S_PERM:  ev_start_nxt = 1'b1;
      S_SCHK:  ev_start_nxt = 1'b1;
      S_GRID:  ev_start_nxt = ev_stat.done && !((kr_r == GRID_LAST) && (ka_r == GRID_LAST));
      S_SRCH:  ev_start_nxt = ev_stat.done && (j_r != DIR_RATIO_DN);
      default: ev_start_nxt = 1'b0;
    endcase
  end

  always_comb begin
    first_c     = (j_r == DIR_AB_UP) || (ev_err < min_err_r);
    min_e       = first_c ? ev_err : min_err_r;
    min_ab_v    = first_c ? pt_ab_r : min_ab_r;
    low_rt_v    = first_c ? pt_ratio_r : low_rt_r;
    j_next      = dir_t'(j_r + 2'd1);
    fa          = ev_a;
    fb          = best_ab_r - ev_a;
    fc          = ONE_Q - best_ab_r;
    x           = prod_r[FRAC_BITS +: X_W];
    x3          = x * RECIP3;
    case (count_eff)
      2'd1:    qv = x[OUT_W-1:0];
      2'd2:    qv = x[OUT_W:1];
      default: qv = x3[RECIP_SH +: OUT_W];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ev_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ev_start_r <= ev_start_nxt;
      if (out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            sl_r     <= q_data.sl;
            sh_r     <= q_data.sh;
            last_r   <= q_data.last;
            perm_r   <= 2'd0;
            tot_r[0] <= '0;
            tot_r[1] <= '0;
            tot_r[2] <= '0;
            state_r  <= S_PERM;
          end
        end
        S_PERM: begin
          dd12_l_r     <= {da_l[15], da_l} - {db_l[15], db_l};
          dd23_l_r     <= {db_l[15], db_l} - {dc_l[15], dc_l};
          off_l_r      <= {dc_l[15], dc_l} - {sl_r[15], sl_r};
          dd12_h_r     <= {da_h[15], da_h} - {db_h[15], db_h};
          dd23_h_r     <= {db_h[15], db_h} - {dc_h[15], dc_h};
          off_h_r      <= {dc_h[15], dc_h} - {sh_r[15], sh_r};
          best_ab_r    <= '0;
          best_rt_r    <= '0;
          best_err_r   <= START_ERR;
          ka_r         <= 4'd0;
          kr_r         <= 4'd0;
          pt_ab_r      <= GRID[0];
          pt_ratio_r   <= GRID[0];
          state_r      <= S_GRID;
        end
        S_GRID: begin
          if (ev_stat.done) begin
            if (ev_err < best_err_r) begin
              best_err_r   <= ev_err;
              best_ab_r    <= pt_ab_r;
              best_rt_r    <= pt_ratio_r;
            end
            if (kr_r == GRID_LAST) begin
              if (ka_r == GRID_LAST) begin
                step_r    <= STEP0;
                cur_err_r <= START_ERR;
                state_r   <= S_SCHK;
              end else begin
                ka_r       <= ka_r + 4'd1;
                kr_r       <= 4'd0;
                pt_ab_r    <= GRID[ka_r + 4'd1];
                pt_ratio_r <= GRID[0];
              end
            end else begin
              kr_r       <= kr_r + 4'd1;
              pt_ratio_r <= GRID[kr_r + 4'd1];
            end
          end
        end
        S_SCHK: begin
          if (search_go) begin
            j_r        <= DIR_AB_UP;
            pt_ab_r    <= cand_ab(DIR_AB_UP, best_ab_r, step_r);
            pt_ratio_r <= cand_ratio(DIR_AB_UP, best_rt_r, step_r);
            state_r    <= S_SRCH;
          end else begin
            pt_ab_r    <= best_ab_r;
            pt_ratio_r <= best_rt_r;
            state_r    <= S_FINAL;
          end
        end
        S_SRCH: begin
          if (ev_stat.done) begin
            if (j_r == DIR_RATIO_DN) begin
              if (min_e < cur_err_r) begin
                best_ab_r    <= min_ab_v;
                best_rt_r    <= low_rt_v;
                cur_err_r    <= min_e;
              end else begin
                step_r <= step_r >> 1;
              end
              state_r <= S_SCHK;
            end else begin
              min_err_r   <= min_e;
              min_ab_r    <= min_ab_v;
              low_rt_r    <= low_rt_v;
              j_r         <= j_next;
              pt_ab_r     <= cand_ab(j_next, best_ab_r, step_r);
              pt_ratio_r  <= cand_ratio(j_next, best_rt_r, step_r);
            end
          end
        end
        S_FINAL: begin
          if (ev_stat.done) begin
            case (perm_r)
              2'd0: begin
                tot_r[0] <= tot_r[0] + TW'(fa);
                tot_r[1] <= tot_r[1] + TW'(fb);
                tot_r[2] <= tot_r[2] + TW'(fc);
              end
              2'd1: begin
                tot_r[2] <= tot_r[2] + TW'(fa);
                tot_r[0] <= tot_r[0] + TW'(fb);
                tot_r[1] <= tot_r[1] + TW'(fc);
              end
              default: begin
                tot_r[1] <= tot_r[1] + TW'(fa);
                tot_r[2] <= tot_r[2] + TW'(fb);
                tot_r[0] <= tot_r[0] + TW'(fc);
              end
            endcase
            if (perm_r == count_eff - 2'd1) begin
              fidx_r  <= 2'd0;
              state_r <= S_OMUL;
            end else begin
              perm_r  <= perm_r + 2'd1;
              state_r <= S_PERM;
            end
          end
        end
        S_OMUL: begin
          prod_r  <= tot_r[fidx_r] * OMAX;
          state_r <= S_ODIV;
        end
        S_ODIV: begin
          q_r[fidx_r] <= qv;
          if (fidx_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            fidx_r  <= fidx_r + 2'd1;
            state_r <= S_OMUL;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            f1_r        <= q_r[0];
            f2_r        <= q_r[1];
            f3_r        <= q_r[2];
            last_out_r  <= last_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fraction_one   = f1_r;
  assign out_fraction_two   = f2_r;
  assign out_fraction_three = f3_r;
  assign out_last_out       = last_out_r;

endmodule

@@ src/three_material_voxel_decomposition_unit.sv @@
// per ordering: 121 grid points, four points per search round and one final point, each
//   evaluated on the shared multiplier in the point evaluator, plus a check state per search
//   round, then a multiply and a divide state per fraction and a load of the result register
// the back end takes one transaction at a time
// a two-entry queue lets the front take up to two more transactions meanwhile
// reset: synchronous active-low rst_n clears control state and loads register defaults
`timescale 1ns / 1ps
module three_material_voxel_decomposition_unit #(
  parameter int OUT_MAX   = 65535,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_low,
  input  logic signed [15:0] in_sample_high,
  input  logic               in_last_voxel,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_fraction_one,
  output logic [15:0]        out_fraction_two,
  output logic [15:0]        out_fraction_three,
  output logic               out_last_out,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tmvd_pkg::*;

  cfg_t     cfg_r;
  q_stat_t  q_stat;
  vox_t     push_data, pop_data;
  logic     push, pop;
  reg_idx_t reg_idx;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;

  // register file, written in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.perm_count <= 2'd1;
      cfg_r.dl1        <= '0;
      cfg_r.dl2        <= '0;
      cfg_r.dl3        <= '0;
      cfg_r.dh1        <= '0;
      cfg_r.dh2        <= '0;
      cfg_r.dh3        <= '0;
      cfg_r.stop_step  <= STOP_W'(66);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PERM_COUNT: cfg_r.perm_count <= pwdata[1:0];
        REG_MAT1_LOW:   cfg_r.dl1        <= pwdata[15:0];
        REG_MAT2_LOW:   cfg_r.dl2        <= pwdata[15:0];
        REG_MAT3_LOW:   cfg_r.dl3        <= pwdata[15:0];
        REG_MAT1_HIGH:  cfg_r.dh1        <= pwdata[15:0];
        REG_MAT2_HIGH:  cfg_r.dh2        <= pwdata[15:0];
        REG_MAT3_HIGH:  cfg_r.dh3        <= pwdata[15:0];
        REG_STOP_STEP:  cfg_r.stop_step  <= pwdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_PERM_COUNT: prdata = {30'b0, cfg_r.perm_count};
      REG_MAT1_LOW:   prdata = {16'b0, cfg_r.dl1};
      REG_MAT2_LOW:   prdata = {16'b0, cfg_r.dl2};
      REG_MAT3_LOW:   prdata = {16'b0, cfg_r.dl3};
      REG_MAT1_HIGH:  prdata = {16'b0, cfg_r.dh1};
      REG_MAT2_HIGH:  prdata = {16'b0, cfg_r.dh2};
      REG_MAT3_HIGH:  prdata = {16'b0, cfg_r.dh3};
      REG_STOP_STEP:  prdata = {20'b0, cfg_r.stop_step};
      default:        prdata = '0;
    endcase
  end

  // front: clamps samples to the density span and queues them
  tmvd_front u_front (
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_low  (in_sample_low),
    .in_sample_high (in_sample_high),
    .in_last_voxel  (in_last_voxel),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  tmvd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back: grid fit, pattern search, averaging and scaling
  tmvd_back #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_MAX   (OUT_MAX)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_stat             (q_stat),
    .q_data             (pop_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_fraction_one   (out_fraction_one),
    .out_fraction_two   (out_fraction_two),
    .out_fraction_three (out_fraction_three),
    .out_last_out       (out_last_out)
  );

  // a queued transaction is visible to the back end on the next cycle
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (q_stat.cnt != 2'd0))
    else $error("accepted transaction not held in queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
